>>> rtl/float_add_sub_truncating_top_assert.svh
// Assertion macros used by the checker module of the adder/subtractor.
// Each macro expands to one labeled concurrent assertion that is disabled
// while reset is held.
`ifndef FLOAT_ADD_SUB_TRUNCATING_TOP_ASSERT_SVH
`define FLOAT_ADD_SUB_TRUNCATING_TOP_ASSERT_SVH

// Same-cycle implication.
`define FAS_ASSERT_SAME(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define FAS_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/fas_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fas_pkg
// Widths, constants and stage types of the truncating float adder/subtractor.
// ----------------------------------------------------------------------------
package fas_pkg;

    localparam int FRAC_BITS = 23;
    localparam int EXP_BITS  = 8;
    localparam int GUARD     = 9;

    // Significand with its hidden one, aligned word, and sum with carry room.
    localparam int SIG_W  = FRAC_BITS + 1;
    localparam int WIDE_W = SIG_W + GUARD;
    localparam int MAG_W  = WIDE_W + 1;

    // Normalization shift count and the split of its steps over two stages.
    localparam int CNT_W      = $clog2(MAG_W);
    localparam int NORM_SPLIT = CNT_W / 2;

    // Exponent offset of a normalized sum: position of the sum's top bit
    // minus the fraction and guard widths.
    localparam int EXP_ADJ = MAG_W - 1 - FRAC_BITS - GUARD;

    typedef struct packed {
        logic [SIG_W-1:0]    big;
        logic [SIG_W-1:0]    small_sig;
        logic [EXP_BITS-1:0] ebig;
        logic [EXP_BITS-1:0] diff;
        logic                big_is_b;
        logic                add;
        logic                zero;
    } fas_order_t;

    typedef struct packed {
        logic [SIG_W-1:0]    big;
        logic [WIDE_W-1:0]   small_w;
        logic                sticky;
        logic [EXP_BITS-1:0] ebig;
        logic                big_is_b;
        logic                add;
        logic                zero;
    } fas_wide_t;

    typedef struct packed {
        logic [MAG_W-1:0]    mag;
        logic [CNT_W-1:0]    cnt;
        logic [EXP_BITS-1:0] ebig;
        logic                sign;
        logic                zero;
    } fas_sum_t;

endpackage

>>> rtl/fas_align.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fas_align
// Two pipeline stages: order the operands by magnitude, then shift the
// smaller significand right by the exponent difference with a sticky bit.
// ----------------------------------------------------------------------------
module fas_align
    import fas_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 adv,
    input  logic                 in_valid,
    input  logic [FRAC_BITS-1:0] frac_a,
    input  logic [FRAC_BITS-1:0] frac_b,
    input  logic [EXP_BITS-1:0]  exp_a,
    input  logic [EXP_BITS-1:0]  exp_b,
    input  logic                 req_type,
    output logic                 out_valid,
    output fas_wide_t            out_data
);

    logic       ord_valid_reg;
    fas_order_t ord_reg;
    fas_order_t ord_next;
    logic       wide_valid_reg;
    fas_wide_t  wide_reg;
    fas_wide_t  wide_next;

    always_comb begin
        logic [SIG_W-1:0] sig_a;
        logic [SIG_W-1:0] sig_b;
        logic             b_wins;
        sig_a  = {1'b1, frac_a};
        sig_b  = {1'b1, frac_b};
        // On equal exponents the larger significand goes first.
        b_wins = (exp_b > exp_a) || ((exp_b == exp_a) && (sig_b > sig_a));
        ord_next.big_is_b  = b_wins;
        ord_next.big       = b_wins ? sig_b : sig_a;
        ord_next.small_sig = b_wins ? sig_a : sig_b;
        ord_next.ebig      = b_wins ? exp_b : exp_a;
        ord_next.diff      = b_wins ? (exp_b - exp_a) : (exp_a - exp_b);
        ord_next.add       = req_type;
        ord_next.zero      = !req_type && (exp_a == exp_b) && (frac_a == frac_b);
    end

    always_comb begin
        logic [WIDE_W-1:0] ext;
        logic [WIDE_W-1:0] low_mask;
        ext      = {ord_reg.small_sig, {GUARD{1'b0}}};
        low_mask = (WIDE_W'(1) << ord_reg.diff) - WIDE_W'(1);
        wide_next.big      = ord_reg.big;
        wide_next.ebig     = ord_reg.ebig;
        wide_next.big_is_b = ord_reg.big_is_b;
        wide_next.add      = ord_reg.add;
        wide_next.zero     = ord_reg.zero;
        if (32'(ord_reg.diff) >= WIDE_W) begin
            // The whole significand falls off; its hidden one makes it nonzero.
            wide_next.small_w = '0;
            wide_next.sticky  = 1'b1;
        end else begin
            wide_next.small_w = ext >> ord_reg.diff;
            wide_next.sticky  = |(ext & low_mask);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ord_valid_reg  <= 1'b0;
            wide_valid_reg <= 1'b0;
        end else if (adv) begin
            ord_valid_reg  <= in_valid;
            wide_valid_reg <= ord_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            ord_reg  <= ord_next;
            wide_reg <= wide_next;
        end
    end

    assign out_valid = wide_valid_reg;
    assign out_data  = wide_reg;

endmodule

>>> rtl/fas_addsub.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fas_addsub
// One pipeline stage: add or subtract the aligned significands, with the
// sticky bit taken as a borrow in a subtraction.
// ----------------------------------------------------------------------------
module fas_addsub
    import fas_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      adv,
    input  logic      in_valid,
    input  fas_wide_t in_data,
    output logic      out_valid,
    output fas_sum_t  out_data
);

    logic     sum_valid_reg;
    fas_sum_t sum_reg;
    fas_sum_t sum_next;

    always_comb begin
        logic [MAG_W-1:0] big_ext;
        logic [MAG_W-1:0] small_ext;
        big_ext   = {1'b0, in_data.big, {GUARD{1'b0}}};
        small_ext = {1'b0, in_data.small_w};
        sum_next.cnt  = '0;
        sum_next.ebig = in_data.ebig;
        sum_next.zero = in_data.zero;
        if (in_data.add) begin
            sum_next.mag  = big_ext + small_ext;
            sum_next.sign = 1'b0;
        end else begin
            sum_next.mag  = big_ext - small_ext - MAG_W'(in_data.sticky);
            sum_next.sign = in_data.big_is_b;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sum_valid_reg <= 1'b0;
        end else if (adv) begin
            sum_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            sum_reg <= sum_next;
        end
    end

    assign out_valid = sum_valid_reg;
    assign out_data  = sum_reg;

endmodule

>>> rtl/fas_norm.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fas_norm
// Two pipeline stages of a binary-search normalizer: the wide shift steps
// first, then the narrow ones with the exponent and the result register.
// ----------------------------------------------------------------------------
module fas_norm
    import fas_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 adv,
    input  logic                 in_valid,
    input  fas_sum_t             in_data,
    output logic                 out_valid,
    output logic [FRAC_BITS-1:0] res_frac,
    output logic [EXP_BITS-1:0]  res_exp,
    output logic                 res_sign,
    output logic                 res_zero
);

    logic                 coarse_valid_reg;
    fas_sum_t             coarse_reg;
    fas_sum_t             coarse_next;
    logic                 res_valid_reg;
    logic [FRAC_BITS-1:0] frac_reg;
    logic [FRAC_BITS-1:0] frac_next;
    logic [EXP_BITS-1:0]  exp_reg;
    logic [EXP_BITS-1:0]  exp_next;
    logic                 sign_reg;
    logic                 sign_next;
    logic                 zero_reg;

    // Each step shifts left by a power of two when that many top bits are zero.
    always_comb begin
        logic [MAG_W-1:0] m;
        logic [CNT_W-1:0] cnt;
        m   = in_data.mag;
        cnt = '0;
        for (int s = CNT_W - 1; s >= NORM_SPLIT; s--) begin
            if ((m >> (MAG_W - (1 << s))) == '0) begin
                m      = m << (1 << s);
                cnt[s] = 1'b1;
            end
        end
        coarse_next      = in_data;
        coarse_next.mag  = m;
        coarse_next.cnt  = cnt;
    end

    always_comb begin
        logic [MAG_W-1:0] m;
        logic [CNT_W-1:0] cnt;
        m   = coarse_reg.mag;
        cnt = coarse_reg.cnt;
        for (int s = NORM_SPLIT - 1; s >= 0; s--) begin
            if ((m >> (MAG_W - (1 << s))) == '0) begin
                m      = m << (1 << s);
                cnt[s] = 1'b1;
            end
        end
        // An exact zero shows all fields cleared.
        if (coarse_reg.zero) begin
            frac_next = '0;
            exp_next  = '0;
            sign_next = 1'b0;
        end else begin
            frac_next = m[MAG_W-2 -: FRAC_BITS];
            exp_next  = coarse_reg.ebig + EXP_BITS'(EXP_ADJ) - EXP_BITS'(cnt);
            sign_next = coarse_reg.sign;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            coarse_valid_reg <= 1'b0;
            res_valid_reg    <= 1'b0;
        end else if (adv) begin
            coarse_valid_reg <= in_valid;
            res_valid_reg    <= coarse_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            coarse_reg <= coarse_next;
            frac_reg   <= frac_next;
            exp_reg    <= exp_next;
            sign_reg   <= sign_next;
            zero_reg   <= coarse_reg.zero;
        end
    end

    assign out_valid = res_valid_reg;
    assign res_frac  = frac_reg;
    assign res_exp   = exp_reg;
    assign res_sign  = sign_reg;
    assign res_zero  = zero_reg;

endmodule

>>> rtl/float_add_sub_truncating_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// float_add_sub_truncating_top
// Unsigned floating adder/subtractor with truncation and a sign output.
// ----------------------------------------------------------------------------
// Operands are 1.frac x 2^exp with a hidden one, no sign and no bias. The
// block takes one operation per clock while s_ready is high. Each
// operation passes five register stages: order, align, add/subtract,
// coarse normalize, fine normalize with the result register. The fraction
// is truncated, the exponent wraps modulo 2^EXP_BITS, and an exact zero
// raises m_res_zero with all other fields zero. The five stages advance
// together; they halt only while a result waits in the output register
// and m_ready is low, so s_ready follows m_ready whenever that register
// is full.
module float_add_sub_truncating_top
    import fas_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic [FRAC_BITS-1:0] s_frac_a,
    input  logic [FRAC_BITS-1:0] s_frac_b,
    input  logic [EXP_BITS-1:0]  s_exp_a,
    input  logic [EXP_BITS-1:0]  s_exp_b,
    input  logic                 s_req_type,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [FRAC_BITS-1:0] m_res_frac,
    output logic [EXP_BITS-1:0]  m_res_exp,
    output logic                 m_res_sign,
    output logic                 m_res_zero
);

    logic      adv;
    logic      wide_valid;
    fas_wide_t wide_data;
    logic      sum_valid;
    fas_sum_t  sum_data;

    assign adv     = !m_valid || m_ready;
    assign s_ready = adv;

    fas_align u_align (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .adv       (adv),
        .in_valid  (s_valid),
        .frac_a    (s_frac_a),
        .frac_b    (s_frac_b),
        .exp_a     (s_exp_a),
        .exp_b     (s_exp_b),
        .req_type  (s_req_type),
        .out_valid (wide_valid),
        .out_data  (wide_data)
    );

    fas_addsub u_addsub (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .adv       (adv),
        .in_valid  (wide_valid),
        .in_data   (wide_data),
        .out_valid (sum_valid),
        .out_data  (sum_data)
    );

    fas_norm u_norm (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .adv       (adv),
        .in_valid  (sum_valid),
        .in_data   (sum_data),
        .out_valid (m_valid),
        .res_frac  (m_res_frac),
        .res_exp   (m_res_exp),
        .res_sign  (m_res_sign),
        .res_zero  (m_res_zero)
    );

endmodule

>>> rtl/fas_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fas_checker
// Port-level checks of the adder/subtractor, bound to the top level.
// ----------------------------------------------------------------------------
`include "float_add_sub_truncating_top_assert.svh"

module fas_checker
    import fas_pkg::*;
(
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 s_valid,
    input logic                 s_ready,
    input logic [FRAC_BITS-1:0] s_frac_a,
    input logic [FRAC_BITS-1:0] s_frac_b,
    input logic [EXP_BITS-1:0]  s_exp_a,
    input logic [EXP_BITS-1:0]  s_exp_b,
    input logic                 s_req_type,
    input logic                 m_valid,
    input logic                 m_ready,
    input logic [FRAC_BITS-1:0] m_res_frac,
    input logic [EXP_BITS-1:0]  m_res_exp,
    input logic                 m_res_sign,
    input logic                 m_res_zero
);

    // A zero result carries no other information.
    `FAS_ASSERT_SAME(a_zero_clears, aclk, aresetn, m_valid && m_res_zero, (m_res_frac == '0) && (m_res_exp == '0) && !m_res_sign, "zero result with nonzero fields")

    // A stalled result holds until its transfer.
    `FAS_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_res_frac) && $stable(m_res_exp) && $stable(m_res_sign) && $stable(m_res_zero), "stalled result changed")

    // The pipeline takes an operation whenever the output can drain.
    `FAS_ASSERT_SAME(a_ready_on_drain, aclk, aresetn, m_ready, s_ready, "input stalled while output drains")

    // An empty output register never blocks the input.
    `FAS_ASSERT_SAME(a_ready_when_empty, aclk, aresetn, !m_valid, s_ready, "input stalled with empty output")

endmodule

bind float_add_sub_truncating_top fas_checker u_fas_checker (.*);
